// ===== design/spectrum_profile_table_defines.svh =====
// assertion macros for the spectrum profile table
`ifndef SPECTRUM_PROFILE_TABLE_DEFINES_SVH
`define SPECTRUM_PROFILE_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define SPT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("spt: assertion failed");
// condition must never be seen outside reset
`define SPT_ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("spt: forbidden condition seen");
`else
`define SPT_ASSERT(lbl, clk, rstn, prop)
`define SPT_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

// ===== design/spt_pkg.sv =====
// types, codes and defaults shared by the spectrum profile table
`default_nettype none
package spt_pkg;

    localparam int SLOTS_DEFAULT = 8;
    localparam int BANDS_DEFAULT = 32;

    typedef enum logic [2:0] {
        CMD_PUBLISH = 3'd0,
        CMD_REMOVE  = 3'd1,
        CMD_READ    = 3'd2,
        CMD_COLLIDE = 3'd3,
        CMD_CLEAR   = 3'd4
    } spt_cmd_e;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_FULL      = 3'd2,
        ST_ZERO_KEY  = 3'd3,
        ST_SUMMARY   = 3'd4
    } spt_status_e;

    typedef enum logic [1:0] {
        KIND_SINGLE = 2'd0,
        KIND_READ   = 2'd1,
        KIND_HIT    = 2'd2,
        KIND_SUM    = 2'd3
    } spt_kind_e;

    typedef struct packed {
        logic [2:0]         command;
        logic [63:0]        key_id;
        logic [63:0]        peer_id;
        logic [4:0]         band_number;
        logic signed [15:0] band_value;
        logic [31:0]        profile_sequence;
        logic               final_band;
        logic signed [15:0] threshold_level;
    } spt_item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [4:0]         band_out;
        logic signed [15:0] level_out;
        logic [31:0]        sequence_out;
        logic [5:0]         collision_count;
        logic               last_result;
    } spt_result_t;

    // controller to datapath
    typedef struct packed {
        logic        accept;
        logic        srch_start;
        logic        srch_step;
        logic        stg_clear;
        logic        cp_rd;
        logic        cp_wr;
        logic        commit;
        logic        remove;
        logic        clear_all;
        logic        rd_a;
        logic        rd_b0;
        logic        rd_bn;
        logic        load_b0;
        logic        load_next;
        logic        eval;
        logic        shift;
        logic        band_clr;
        logic        band_inc;
        logic        push;
        spt_kind_e   kind;
        spt_status_e st;
    } spt_ctl_t;

    // datapath to controller
    typedef struct packed {
        logic [2:0] cmd;
        logic       key_zero;
        logic       final_band;
        logic       srch_done;
        logic       found_a;
        logic       found_b;
        logic       free_found;
        logic       band_last;
        logic       col_hit;
        logic       out_free;
    } spt_sts_t;

endpackage
`default_nettype wire

// ===== design/spectrum_profile_table.sv =====
// top level of the spectrum profile table
// usage:
//   item channel (item_valid / item_ready / item) takes one command per transfer:
//   publish band, remove, read, collide or clear. result channel
//   (result_valid / result_ready / result) gives the results of that command,
//   the last one marked by last_result. a non-final publish gives none.
// steps, one command at a time, before any output wait:
//   non-final publish: accept, dispatch. clear: accept, dispatch, emit.
//   key lookup walks the slot directory one slot per cycle.
//   remove: lookup, then emit. final publish: lookup, then a staging read and
//   a band store write per band, copying staging into the band store, then emit.
//   read: lookup, then a store read and a result per band.
//   collide: lookup, a read and a load of b's first band, then per band a read
//   of b's next band and of a's band, compare and window shift, one more step per
//   colliding band and one for the summary.
// reset clears the directory active marks and the staging buffer at once,
//   no clearing pass is needed; band store contents are only read for slots
//   that a commit has filled.
// a stalled receiver holds the result register; the sequencer waits and
//   takes no new command until the current one's last result is registered.
`default_nettype none
module spectrum_profile_table #(
    parameter int SLOTS = spt_pkg::SLOTS_DEFAULT,
    parameter int BANDS = spt_pkg::BANDS_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_ready,
    input  wire spt_pkg::spt_item_t  item,
    output logic                     result_valid,
    input  wire logic                result_ready,
    output spt_pkg::spt_result_t     result
);
    import spt_pkg::*;

    // command and status between sequencer and datapath
    spt_ctl_t ctl;
    spt_sts_t sts;

    spt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .sts        (sts),
        .ctl        (ctl)
    );

    spt_datapath #(
        .SLOTS (SLOTS),
        .BANDS (BANDS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .ctl          (ctl),
        .sts          (sts),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
`default_nettype wire

// ===== design/spt_ctrl.sv =====
// command sequencer for the spectrum profile table
`default_nettype none
module spt_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire spt_pkg::spt_sts_t sts,
    output spt_pkg::spt_ctl_t      ctl
);
    import spt_pkg::*;

    typedef enum logic [15:0] {
        S_IDLE     = 16'h0001,
        S_DISPATCH = 16'h0002,
        S_SRCH     = 16'h0004,
        S_CP_RD    = 16'h0008,
        S_CP_WR    = 16'h0010,
        S_EMIT     = 16'h0020,
        S_R_IS     = 16'h0040,
        S_R_EM     = 16'h0080,
        S_C_RB0    = 16'h0100,
        S_C_LB0    = 16'h0200,
        S_C_RN     = 16'h0400,
        S_C_RA     = 16'h0800,
        S_C_EV     = 16'h1000,
        S_C_HIT    = 16'h2000,
        S_C_ADV    = 16'h4000,
        S_C_SUM    = 16'h8000
    } state_t;

    state_t      state_reg, state_next;
    spt_status_e st_reg, st_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            st_reg    <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end

    always_comb
    begin
        ctl        = '0;
        ctl.kind   = KIND_SINGLE;
        ctl.st     = st_reg;
        state_next = state_reg;
        st_next    = st_reg;
        item_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    ctl.accept = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (sts.cmd)
                    CMD_PUBLISH:
                    begin
                        if (!sts.final_band)
                            state_next = S_IDLE;
                        else if (sts.key_zero)
                        begin
                            ctl.stg_clear = 1'b1;
                            st_next       = ST_ZERO_KEY;
                            state_next    = S_EMIT;
                        end
                        else
                        begin
                            ctl.srch_start = 1'b1;
                            state_next     = S_SRCH;
                        end
                    end
                    CMD_REMOVE, CMD_READ, CMD_COLLIDE:
                    begin
                        ctl.srch_start = 1'b1;
                        state_next     = S_SRCH;
                    end
                    CMD_CLEAR:
                    begin
                        ctl.clear_all = 1'b1;
                        st_next       = ST_OK;
                        state_next    = S_EMIT;
                    end
                    default:
                        state_next = S_IDLE;
                endcase
            end
            S_SRCH:
            begin
                if (!sts.srch_done)
                    ctl.srch_step = 1'b1;
                else
                begin
                    case (sts.cmd)
                        CMD_PUBLISH:
                        begin
                            if (!sts.found_a && !sts.free_found)
                            begin
                                ctl.stg_clear = 1'b1;
                                st_next       = ST_FULL;
                                state_next    = S_EMIT;
                            end
                            else
                            begin
                                ctl.band_clr = 1'b1;
                                state_next   = S_CP_RD;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            ctl.remove = sts.found_a;
                            st_next    = sts.found_a ? ST_OK : ST_NOT_FOUND;
                            state_next = S_EMIT;
                        end
                        CMD_READ:
                        begin
                            if (sts.found_a)
                            begin
                                ctl.band_clr = 1'b1;
                                state_next   = S_R_IS;
                            end
                            else
                            begin
                                st_next    = ST_NOT_FOUND;
                                state_next = S_EMIT;
                            end
                        end
                        CMD_COLLIDE:
                        begin
                            if (sts.found_a && sts.found_b)
                            begin
                                ctl.band_clr = 1'b1;
                                state_next   = S_C_RB0;
                            end
                            else
                            begin
                                st_next    = ST_NOT_FOUND;
                                state_next = S_EMIT;
                            end
                        end
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_CP_RD:
            begin
                ctl.cp_rd  = 1'b1;
                state_next = S_CP_WR;
            end
            S_CP_WR:
            begin
                ctl.cp_wr = 1'b1;
                if (sts.band_last)
                begin
                    ctl.commit    = 1'b1;
                    ctl.stg_clear = 1'b1;
                    st_next       = ST_OK;
                    state_next    = S_EMIT;
                end
                else
                begin
                    ctl.band_inc = 1'b1;
                    state_next   = S_CP_RD;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    ctl.push   = 1'b1;
                    ctl.kind   = KIND_SINGLE;
                    state_next = S_IDLE;
                end
            end
            S_R_IS:
            begin
                ctl.rd_a   = 1'b1;
                state_next = S_R_EM;
            end
            S_R_EM:
            begin
                if (sts.out_free)
                begin
                    ctl.push = 1'b1;
                    ctl.kind = KIND_READ;
                    if (sts.band_last)
                        state_next = S_IDLE;
                    else
                    begin
                        ctl.band_inc = 1'b1;
                        state_next   = S_R_IS;
                    end
                end
            end
            S_C_RB0:
            begin
                ctl.rd_b0  = 1'b1;
                state_next = S_C_LB0;
            end
            S_C_LB0:
            begin
                ctl.load_b0 = 1'b1;
                state_next  = S_C_RN;
            end
            S_C_RN:
            begin
                ctl.rd_bn  = !sts.band_last;
                state_next = S_C_RA;
            end
            S_C_RA:
            begin
                ctl.load_next = 1'b1;
                ctl.rd_a      = 1'b1;
                state_next    = S_C_EV;
            end
            S_C_EV:
            begin
                ctl.eval   = 1'b1;
                state_next = sts.col_hit ? S_C_HIT : S_C_ADV;
            end
            S_C_HIT:
            begin
                if (sts.out_free)
                begin
                    ctl.push   = 1'b1;
                    ctl.kind   = KIND_HIT;
                    state_next = S_C_ADV;
                end
            end
            S_C_ADV:
            begin
                ctl.shift = 1'b1;
                if (sts.band_last)
                    state_next = S_C_SUM;
                else
                begin
                    ctl.band_inc = 1'b1;
                    state_next   = S_C_RN;
                end
            end
            S_C_SUM:
            begin
                if (sts.out_free)
                begin
                    ctl.push   = 1'b1;
                    ctl.kind   = KIND_SUM;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== design/spt_datapath.sv =====
// slot directory, band store, staging buffer and result register
`default_nettype none
`include "spectrum_profile_table_defines.svh"
module spt_datapath #(
    parameter int SLOTS = spt_pkg::SLOTS_DEFAULT,
    parameter int BANDS = spt_pkg::BANDS_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire spt_pkg::spt_item_t   item,
    input  wire spt_pkg::spt_ctl_t    ctl,
    output spt_pkg::spt_sts_t         sts,
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output spt_pkg::spt_result_t      result
);
    import spt_pkg::*;

    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int BW    = $clog2(BANDS);
    localparam int DEPTH = SLOTS * BANDS;
    localparam int AW    = $clog2(DEPTH);

    spt_item_t item_reg;

    // slot directory
    logic [63:0]      key_mem [SLOTS];
    logic [31:0]      seq_mem [SLOTS];
    logic [SLOTS-1:0] active_reg;
    logic [63:0]      key_rd_reg;
    logic [31:0]      seq_rd_reg;

    // search walk
    logic [CW-1:0] srch_cnt_reg;
    logic          rd_vld_reg;
    logic [SW-1:0] rd_idx_reg;
    logic          found_a_reg, found_b_reg, free_found_reg;
    logic [SW-1:0] slot_a_reg, slot_b_reg, slot_f_reg;
    logic [31:0]   seq_a_reg;
    logic [SW-1:0] tgt;
    logic          walk_rd;

    // band store and staging buffer
    logic signed [15:0] band_mem [DEPTH];
    logic signed [15:0] band_rd_reg;
    logic signed [15:0] stg_mem [BANDS];
    logic [BANDS-1:0]   stg_vld_reg;
    logic signed [15:0] stg_rd_reg;
    logic               stg_rdv_reg;
    logic               stg_wr;
    logic [BW-1:0]      b_reg;
    logic               band_last;
    logic [AW-1:0]      rd_addr, wr_addr;
    logic [SW-1:0]      rd_slot;
    logic [BW-1:0]      rd_band;

    // collide window
    logic signed [15:0] prev_reg, cur_reg, next_reg, col_lvl_reg;
    logic signed [15:0] max3, max2;
    logic               col_hit;
    logic [5:0]         col_cnt_reg;

    logic        out_vld_reg;
    spt_result_t out_reg, out_next;
    logic        out_free;
    logic        commit_legal;

    assign tgt       = found_a_reg ? slot_a_reg : slot_f_reg;
    assign band_last = (b_reg == BW'(BANDS - 1));
    assign walk_rd   = ctl.srch_step && (srch_cnt_reg < CW'(SLOTS));
    assign stg_wr    = ctl.accept && (item.command == CMD_PUBLISH)
                       && ({1'b0, item.band_number} < 6'(BANDS));
    assign out_free  = !out_vld_reg || result_ready;

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
            item_reg <= item;
    end

    // directory memories
    always_ff @(posedge clk)
    begin
        if (walk_rd)
        begin
            key_rd_reg <= key_mem[srch_cnt_reg[SW-1:0]];
            seq_rd_reg <= seq_mem[srch_cnt_reg[SW-1:0]];
        end
        if (ctl.commit)
        begin
            key_mem[tgt] <= item_reg.key_id;
            seq_mem[tgt] <= item_reg.profile_sequence;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_reg <= '0;
        else if (ctl.clear_all)
            active_reg <= '0;
        else if (ctl.commit)
            active_reg[tgt] <= 1'b1;
        else if (ctl.remove)
            active_reg[slot_a_reg] <= 1'b0;
    end

    // one slot per cycle, compare comes in the cycle after the read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            srch_cnt_reg   <= '0;
            rd_vld_reg     <= 1'b0;
            found_a_reg    <= 1'b0;
            found_b_reg    <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (ctl.srch_start)
        begin
            srch_cnt_reg   <= '0;
            rd_vld_reg     <= 1'b0;
            found_a_reg    <= 1'b0;
            found_b_reg    <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            if (ctl.srch_step)
            begin
                rd_vld_reg <= walk_rd;
                if (walk_rd)
                    srch_cnt_reg <= srch_cnt_reg + 1'b1;
            end
            if (rd_vld_reg)
            begin
                if (active_reg[rd_idx_reg] && key_rd_reg == item_reg.key_id)
                    found_a_reg <= 1'b1;
                if (active_reg[rd_idx_reg] && key_rd_reg == item_reg.peer_id)
                    found_b_reg <= 1'b1;
                if (!active_reg[rd_idx_reg])
                    free_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (walk_rd)
            rd_idx_reg <= srch_cnt_reg[SW-1:0];
        if (rd_vld_reg)
        begin
            if (active_reg[rd_idx_reg] && key_rd_reg == item_reg.key_id && !found_a_reg)
            begin
                slot_a_reg <= rd_idx_reg;
                seq_a_reg  <= seq_rd_reg;
            end
            if (active_reg[rd_idx_reg] && key_rd_reg == item_reg.peer_id && !found_b_reg)
                slot_b_reg <= rd_idx_reg;
            if (!active_reg[rd_idx_reg] && !free_found_reg)
                slot_f_reg <= rd_idx_reg;
        end
    end

    // staging buffer, unwritten entries read as zero
    always_ff @(posedge clk)
    begin
        if (stg_wr)
            stg_mem[BW'(item.band_number)] <= item.band_value;
        if (ctl.cp_rd)
        begin
            stg_rd_reg  <= stg_mem[b_reg];
            stg_rdv_reg <= stg_vld_reg[b_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stg_vld_reg <= '0;
        else if (ctl.stg_clear || ctl.clear_all)
            stg_vld_reg <= '0;
        else if (stg_wr)
            stg_vld_reg[BW'(item.band_number)] <= 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_reg <= '0;
        else if (ctl.band_clr)
            b_reg <= '0;
        else if (ctl.band_inc)
            b_reg <= BW'(b_reg + 1'b1);
    end

    // band store addressing
    always_comb
    begin
        rd_slot = slot_a_reg;
        rd_band = b_reg;
        if (ctl.rd_b0)
        begin
            rd_slot = slot_b_reg;
            rd_band = '0;
        end
        else if (ctl.rd_bn)
        begin
            rd_slot = slot_b_reg;
            rd_band = BW'(b_reg + 1'b1);
        end
    end

    assign rd_addr = AW'(AW'(rd_slot) * AW'(BANDS)) + AW'(rd_band);
    assign wr_addr = AW'(AW'(tgt) * AW'(BANDS)) + AW'(b_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.cp_wr)
            band_mem[wr_addr] <= stg_rdv_reg ? stg_rd_reg : 16'sd0;
        if (ctl.rd_a || ctl.rd_b0 || ctl.rd_bn)
            band_rd_reg <= band_mem[rd_addr];
    end

    // neighbor window of profile b, clipped at both table edges
    assign max2    = (prev_reg > cur_reg) ? prev_reg : cur_reg;
    assign max3    = (max2 > next_reg) ? max2 : next_reg;
    assign col_hit = (band_rd_reg > item_reg.threshold_level)
                     && (max3 > item_reg.threshold_level);

    always_ff @(posedge clk)
    begin
        if (ctl.load_b0)
        begin
            prev_reg <= band_rd_reg;
            cur_reg  <= band_rd_reg;
        end
        else if (ctl.shift)
        begin
            prev_reg <= cur_reg;
            cur_reg  <= next_reg;
        end
        if (ctl.load_next)
            next_reg <= band_last ? cur_reg : band_rd_reg;
        if (ctl.eval)
            col_lvl_reg <= (band_rd_reg < max3) ? band_rd_reg : max3;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            col_cnt_reg <= '0;
        else if (ctl.srch_start)
            col_cnt_reg <= '0;
        else if (ctl.push && ctl.kind == KIND_HIT)
            col_cnt_reg <= col_cnt_reg + 1'b1;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (ctl.push)
            out_vld_reg <= 1'b1;
        else if (result_ready)
            out_vld_reg <= 1'b0;
    end

    always_comb
    begin
        out_next = out_reg;
        if (ctl.push)
        begin
            out_next = '0;
            case (ctl.kind)
                KIND_SINGLE:
                begin
                    out_next.status      = ctl.st;
                    out_next.last_result = 1'b1;
                end
                KIND_READ:
                begin
                    out_next.status       = ST_OK;
                    out_next.band_out     = 5'(b_reg);
                    out_next.level_out    = band_rd_reg;
                    out_next.sequence_out = seq_a_reg;
                    out_next.last_result  = band_last;
                end
                KIND_HIT:
                begin
                    out_next.status    = ST_OK;
                    out_next.band_out  = 5'(b_reg);
                    out_next.level_out = col_lvl_reg;
                end
                KIND_SUM:
                begin
                    out_next.status          = ST_SUMMARY;
                    out_next.collision_count = col_cnt_reg;
                    out_next.last_result     = 1'b1;
                end
                default:
                    out_next.status = ctl.st;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result_valid = out_vld_reg;
    assign result       = out_reg;

    assign sts.cmd        = item_reg.command;
    assign sts.key_zero   = (item_reg.key_id == 64'd0);
    assign sts.final_band = item_reg.final_band;
    assign sts.srch_done  = (srch_cnt_reg == CW'(SLOTS)) && !rd_vld_reg;
    assign sts.found_a    = found_a_reg;
    assign sts.found_b    = found_b_reg;
    assign sts.free_found = free_found_reg;
    assign sts.band_last  = band_last;
    assign sts.col_hit    = col_hit;
    assign sts.out_free   = out_free;

    // a commit needs a nonzero key and a target slot
    assign commit_legal = (item_reg.key_id != 64'd0) && (found_a_reg || free_found_reg);

    `SPT_ASSERT(a_push_free, clk, rst_n, ctl.push |-> out_free)
    `SPT_ASSERT(a_commit_ok, clk, rst_n, ctl.commit |-> commit_legal)
    `SPT_ASSERT(a_walk_range, clk, rst_n, srch_cnt_reg <= CW'(SLOTS))
    `SPT_ASSERT(a_col_count, clk, rst_n, col_cnt_reg <= 6'(BANDS))
    `SPT_ASSERT_NEVER(a_commit_clear, clk, rst_n, ctl.commit && !ctl.stg_clear)

endmodule
`default_nettype wire
